[hw/rtl/ihex_pkg.sv]
package ihex_pkg;

  // result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // record types with special handling
  localparam logic [2:0] TYPE_DATA    = 3'd0;
  localparam logic [2:0] TYPE_SEGMENT = 3'd2;
  localparam logic [2:0] TYPE_LINEAR  = 3'd4;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] MAX_LEN_RST  = 8'hFF;

  // parser phase: 0 hunts for a colon, 1..10 walk the record nibbles
  typedef logic [3:0] phase_t;

  localparam phase_t PH_HUNT     = 4'd0;
  localparam phase_t PH_COUNT_HI = 4'd1;
  localparam phase_t PH_COUNT_LO = 4'd2;
  localparam phase_t PH_ADDRH_LO = 4'd4;
  localparam phase_t PH_ADDRL_LO = 4'd6;
  localparam phase_t PH_TYPE_LO  = 4'd8;
  localparam phase_t PH_DATA_HI  = 4'd9;
  localparam phase_t PH_DATA_LO  = 4'd10;

  typedef struct packed {
    logic        kind;
    logic [31:0] base_address;
    logic [7:0]  byte_offset;
    logic [7:0]  data_value;
    logic [2:0]  record_kind;
    logic        checksum_bad;
    logic        short_record;
    logic [15:0] segment_value;
  } result_t;

endpackage

[hw/rtl/ihex_parse_core.sv]
module ihex_parse_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           char_in,
  input  logic [7:0]           max_len,
  output logic                 res_valid,
  output ihex_pkg::result_t    res
);

  ihex_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [7:0]  decl_r, decl_nxt;
  logic [7:0]  recv_r, recv_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [15:0] seg_r, seg_nxt;
  logic [2:0]  typ_r, typ_nxt;
  logic [7:0]  fdb0_r, fdb0_nxt;
  logic [7:0]  fdb1_r, fdb1_nxt;
  logic [7:0]  sum_r, sum_nxt;

  logic        is_hex;
  logic        is_colon;
  logic [3:0]  nib;
  logic        active;
  logic        hi_nib;
  logic [7:0]  pend_upd;
  logic [7:0]  fdb0_upd, fdb1_upd;

  // record close
  logic [7:0]  fin_pend;
  logic [7:0]  fin_fdb0, fin_fdb1;
  logic [7:0]  fin_sum;
  logic        fin_emit;
  logic [15:0] fin_seg;
  logic [31:0] fin_addr;
  ihex_pkg::result_t fin_res;
  logic        do_finish;

  always_comb begin
    is_hex = 1'b1;
    nib    = 4'd0;
    if (char_in >= 8'h30 && char_in <= 8'h39) begin
      nib = 4'(char_in - 8'h30);
    end else if (char_in >= 8'h41 && char_in <= 8'h46) begin
      nib = 4'(char_in - 8'h37);
    end else if (char_in >= 8'h61 && char_in <= 8'h66) begin
      nib = 4'(char_in - 8'h57);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign is_colon = (char_in == ihex_pkg::CHAR_COLON);
  assign active   = is_hex && (phase_r != ihex_pkg::PH_HUNT) &&
                    (phase_r <= ihex_pkg::PH_DATA_LO);
  assign hi_nib   = phase_r[0];
  assign pend_upd = hi_nib ? {nib, 4'd0} : (pend_r | {4'd0, nib});

  // header bytes also land in slot 0 while nothing has been received
  always_comb begin
    fdb0_upd = fdb0_r;
    fdb1_upd = fdb1_r;
    if (recv_r == 8'd0) begin
      fdb0_upd = hi_nib ? {nib, 4'd0} : (fdb0_r | {4'd0, nib});
    end else if (recv_r == 8'd1) begin
      fdb1_upd = hi_nib ? {nib, 4'd0} : (fdb1_r | {4'd0, nib});
    end
  end

  assign fin_pend = is_colon ? pend_r : pend_upd;
  assign fin_fdb0 = is_colon ? fdb0_r : fdb0_upd;
  assign fin_fdb1 = is_colon ? fdb1_r : fdb1_upd;
  assign fin_sum  = recv_r + {5'd0, typ_r} + addr_r[7:0] + addr_r[15:8] + sum_r;
  assign fin_emit = !(recv_r == 8'd0 && typ_r == ihex_pkg::TYPE_DATA);
  assign fin_seg  = (typ_r == ihex_pkg::TYPE_SEGMENT) ? {fin_fdb0, fin_fdb1} : seg_r;
  assign fin_addr = (typ_r == ihex_pkg::TYPE_LINEAR) ? {fin_fdb0, fin_fdb1, addr_r[15:0]}
                                                      : addr_r;

  always_comb begin
    fin_res.kind          = ihex_pkg::KIND_END;
    fin_res.base_address  = addr_r;
    fin_res.byte_offset   = recv_r;
    fin_res.data_value    = 8'd0;
    fin_res.record_kind   = typ_r;
    fin_res.checksum_bad  = ((8'd0 - fin_sum) ^ fin_pend) != 8'd0;
    fin_res.short_record  = recv_r < decl_r;
    fin_res.segment_value = fin_seg;
  end

  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    decl_nxt  = decl_r;
    recv_nxt  = recv_r;
    addr_nxt  = addr_r;
    seg_nxt   = seg_r;
    typ_nxt   = typ_r;
    fdb0_nxt  = fdb0_r;
    fdb1_nxt  = fdb1_r;
    sum_nxt   = sum_r;
    do_finish = 1'b0;
    res_valid = 1'b0;
    res       = fin_res;

    if (fire && is_colon) begin
      phase_nxt = ihex_pkg::PH_COUNT_HI;
      do_finish = 1'b1;
    end else if (fire && active) begin
      pend_nxt = pend_upd;
      fdb0_nxt = fdb0_upd;
      fdb1_nxt = fdb1_upd;
      if (hi_nib) begin
        phase_nxt = phase_r + 4'd1;
      end else begin
        phase_nxt = phase_r + 4'd1;
        unique case (phase_r)
          ihex_pkg::PH_COUNT_LO: begin
            decl_nxt = pend_upd;
            if (pend_upd > max_len) begin
              phase_nxt = ihex_pkg::PH_HUNT;
              do_finish = 1'b1;
            end
          end
          ihex_pkg::PH_ADDRH_LO: addr_nxt = {addr_r[31:16], pend_upd, 8'd0};
          ihex_pkg::PH_ADDRL_LO: addr_nxt = addr_r | {24'd0, pend_upd};
          ihex_pkg::PH_TYPE_LO: begin
            if (pend_upd[7:3] != 5'd0) begin
              phase_nxt = ihex_pkg::PH_HUNT;
            end else begin
              typ_nxt = pend_upd[2:0];
            end
          end
          default: begin
            if (recv_r < decl_r) begin
              recv_nxt  = recv_r + 8'd1;
              sum_nxt   = sum_r + pend_upd;
              phase_nxt = ihex_pkg::PH_DATA_HI;
              res_valid = 1'b1;
              res.kind          = ihex_pkg::KIND_DATA;
              res.base_address  = addr_r;
              res.byte_offset   = recv_r;
              res.data_value    = pend_upd;
              res.record_kind   = typ_r;
              res.checksum_bad  = 1'b0;
              res.short_record  = 1'b0;
              res.segment_value = seg_r;
            end else begin
              phase_nxt = ihex_pkg::PH_HUNT;
              do_finish = 1'b1;
            end
          end
        endcase
      end
    end

    if (do_finish && fin_emit) begin
      res_valid = 1'b1;
      addr_nxt  = fin_addr;
      seg_nxt   = fin_seg;
      recv_nxt  = 8'd0;
      typ_nxt   = ihex_pkg::TYPE_DATA;
      sum_nxt   = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ihex_pkg::PH_HUNT;
      pend_r  <= 8'd0;
      decl_r  <= 8'd0;
      recv_r  <= 8'd0;
      addr_r  <= 32'd0;
      seg_r   <= 16'd0;
      typ_r   <= 3'd0;
      fdb0_r  <= 8'd0;
      fdb1_r  <= 8'd0;
      sum_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      decl_r  <= decl_nxt;
      recv_r  <= recv_nxt;
      addr_r  <= addr_nxt;
      seg_r   <= seg_nxt;
      typ_r   <= typ_nxt;
      fdb0_r  <= fdb0_nxt;
      fdb1_r  <= fdb1_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

[hw/rtl/intel_hex_record_parser_top.sv]
// intel hex record parser: takes one ascii character per input beat and turns the
// text stream into one result beat per decoded data byte plus one end-of-record beat
// carrying the record type, checksum-error and short-record flags (none for an empty
// type 0 record). a colon starts a new record from anywhere, characters that are
// neither hex digits nor a colon are dropped, and records whose count exceeds
// max_data_length or whose type is above 7 are discarded silently. type 4 records
// set the upper 16 address bits, type 2 the segment value. the parser state advances
// per character, so one character is accepted every clock while in_stall is low;
// results are registered in an output register backed by a one-beat skid stage, so
// in_stall only rises once both hold a result the sink has not taken.
// max_data_length resets to 255 and should only be written while the parser is idle.
module intel_hex_record_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  // character input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [31:0] out_base_address,
  output logic [7:0]  out_byte_offset,
  output logic [7:0]  out_data_value,
  output logic [2:0]  out_record_kind,
  output logic        out_checksum_bad,
  output logic        out_short_record,
  output logic [15:0] out_segment_value,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_max_data_length
);

  logic [7:0] max_len_r;

  logic in_fire;
  logic core_valid;
  ihex_pkg::result_t core_res;

  // output register plus skid stage
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  ihex_pkg::result_t out_r, out_nxt;
  ihex_pkg::result_t skid_r, skid_nxt;
  logic out_take;
  logic new_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= ihex_pkg::MAX_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_max_data_length;
    end
  end

  ihex_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .char_in   (in_char_in),
    .max_len   (max_len_r),
    .res_valid (core_valid),
    .res       (core_res)
  );

  assign out_take = out_valid_r && !out_stall;
  assign new_res  = in_fire && core_valid;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      // input is stalled, drain the skid beat once the output moves
      if (out_take) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (new_res) begin
      if (!out_valid_r || out_take) begin
        out_nxt       = core_res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = core_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_r.kind;
  assign out_base_address  = out_r.base_address;
  assign out_byte_offset   = out_r.byte_offset;
  assign out_data_value    = out_r.data_value;
  assign out_record_kind   = out_r.record_kind;
  assign out_checksum_bad  = out_r.checksum_bad;
  assign out_short_record  = out_r.short_record;
  assign out_segment_value = out_r.segment_value;

`ifndef SYNTHESIS
  // skid stage only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid beat held with empty output register");

  // stall only rises when a new result met a blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(new_res && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  // an output beat taken with nothing behind it leaves the output empty
  a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && !skid_valid_r && !new_res) |=> !out_valid_r)
    else $error("output beat repeated after being taken");

  // end-of-record beats never carry a data byte
  a_end_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == ihex_pkg::KIND_END) |-> out_r.data_value == 8'd0)
    else $error("end-of-record beat with non-zero data");
`endif

endmodule
